// ===== src/rsti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rsti_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int CHAR_WIDTH_DEF  = 16;
    localparam int ADDR_WIDTH      = 3;
    localparam int MODE_WIDTH      = 5;

    localparam logic [0:0] IDX_RADIX_MODE = 1'b0;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_RADIX = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_NO_RADIX  = 2'd3;

    localparam logic [4:0] MODE_AUTO = 5'd0;
    localparam logic [4:0] MODE_HEX  = 5'd16;

    localparam logic [3:0] RADIX_BIN = 4'd2;
    localparam logic [3:0] RADIX_DEC = 4'd10;

    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_A    = 8'h41;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_B    = 8'h42;
    localparam logic [7:0] CH_D    = 8'h44;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_X    = 8'h58;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LZ   = 8'h7A;
    localparam logic [7:0] CH_CASE = 8'h20;
    localparam logic [7:0] HEX_A_VAL = 8'd10;

    typedef struct packed {
        logic [3:0] max_cls;
        logic       hex_bad;
        logic       prefix;
        logic       first_zero;
        logic       first_digit;
    } t_flags;

    typedef struct packed {
        logic       empty;
        logic [7:0] ch;
        logic [1:0] pos;
        t_flags     flags;
    } t_tok;

    function automatic logic [3:0] f_fold_radix(input logic [MODE_WIDTH-1:0] mode);
        logic [3:0] r;
        begin
            if (mode inside {[5'd2:5'd10]}) begin
                r = mode[3:0];
            end else begin
                r = RADIX_DEC;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/radix_string_to_integer_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_char_code, i_last, i_is_empty
// result    out        o_valid / i_stall   o_status, o_value
// config    in         APB psel/penable    paddr, pwdata, prdata (radix_mode)
//
// One character is taken per cycle while o_stall is low, with no gaps between strings.
// A result shows on o_valid after its last character has passed the pipeline stages:
// the input register folds the held character into the second stage, which
// makes the final fold and status decision into the result register.
// Synchronous active-low reset clears the pipeline, the string state and radix_mode.
// i_stall holds the result register; it backs up to o_stall only when a last
// character cannot move on, other characters keep flowing.
module radix_string_to_integer_unit import rsti_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int CHAR_WIDTH  = CHAR_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [CHAR_WIDTH-1:0]  i_char_code,
    input  logic                   i_last,
    input  logic                   i_is_empty,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic [VALUE_WIDTH-1:0] o_value
);

    logic [MODE_WIDTH-1:0]  r_radix_mode;
    logic                   tok_valid;
    logic                   tok_take;
    t_tok                   tok;
    logic [VALUE_WIDTH-1:0] tok_radix;
    logic [VALUE_WIDTH-1:0] tok_bin;
    logic [VALUE_WIDTH-1:0] tok_hex;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == IDX_RADIX_MODE) ?
                    {{(32-MODE_WIDTH){1'b0}}, r_radix_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix_mode <= MODE_AUTO;
        end else if (psel && penable && pwrite && pready && (paddr[2] == IDX_RADIX_MODE)) begin
            r_radix_mode <= pwdata[MODE_WIDTH-1:0];
        end
    end

    rsti_front #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .CHAR_WIDTH (CHAR_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radix_mode(r_radix_mode),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .i_is_empty  (i_is_empty),
        .o_tok_valid (tok_valid),
        .i_tok_take  (tok_take),
        .o_tok       (tok),
        .o_acc_radix (tok_radix),
        .o_acc_bin   (tok_bin),
        .o_acc_hex   (tok_hex)
    );

    rsti_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radix_mode(r_radix_mode),
        .i_tok_valid (tok_valid),
        .o_tok_take  (tok_take),
        .i_tok       (tok),
        .i_acc_radix (tok_radix),
        .i_acc_bin   (tok_bin),
        .i_acc_hex   (tok_hex),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_value     (o_value)
    );

endmodule
`default_nettype wire

// ===== src/rsti_fold.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rsti_fold import rsti_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic [VALUE_WIDTH-1:0] i_acc_radix,
    input  logic [VALUE_WIDTH-1:0] i_acc_bin,
    input  logic [VALUE_WIDTH-1:0] i_acc_hex,
    input  t_flags                 i_flags,
    input  logic [7:0]             i_char,
    input  logic [1:0]             i_idx,
    input  logic [3:0]             i_radix,
    output logic [VALUE_WIDTH-1:0] o_acc_radix,
    output logic [VALUE_WIDTH-1:0] o_acc_bin,
    output logic [VALUE_WIDTH-1:0] o_acc_hex,
    output t_flags                 o_flags
);

    logic                   is_dec;
    logic                   is_af;
    logic                   skip;
    logic [3:0]             digit;
    logic [3:0]             hv;
    logic [3:0]             cls;
    logic [VALUE_WIDTH-1:0] digit_w;
    logic [VALUE_WIDTH-1:0] radix_w;

    always_comb begin
        is_dec  = (i_char >= CH_0) && (i_char <= CH_9);
        is_af   = (i_char >= CH_A) && (i_char <= CH_F);
        digit   = is_dec ? 4'(i_char - CH_0) : 4'd0;
        cls     = is_dec ? digit : 4'hF;
        hv      = is_dec ? digit : (is_af ? 4'(i_char - CH_A + HEX_A_VAL) : 4'd0);
        skip    = (i_idx == 2'd1) && i_flags.first_zero && (i_char == CH_X);
        digit_w = {{(VALUE_WIDTH-4){1'b0}}, digit};
        radix_w = {{(VALUE_WIDTH-4){1'b0}}, i_radix};

        o_flags.first_digit = i_flags.first_digit | ((i_idx == 2'd0) & is_dec);
        o_flags.first_zero  = i_flags.first_zero | ((i_idx == 2'd0) & (i_char == CH_0));
        o_flags.prefix      = i_flags.prefix | skip;
        o_flags.max_cls     = (cls > i_flags.max_cls) ? cls : i_flags.max_cls;
        o_flags.hex_bad     = i_flags.hex_bad | (!skip & !is_dec & !is_af);

        o_acc_hex   = skip ? i_acc_hex : {i_acc_hex[VALUE_WIDTH-5:0], hv};
        o_acc_radix = (i_acc_radix * radix_w) + digit_w;
        o_acc_bin   = {i_acc_bin[VALUE_WIDTH-2:0], 1'b0} + digit_w;
    end

endmodule
`default_nettype wire

// ===== src/rsti_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rsti_front import rsti_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int CHAR_WIDTH  = CHAR_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [MODE_WIDTH-1:0]  i_radix_mode,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [CHAR_WIDTH-1:0]  i_char_code,
    input  logic                   i_last,
    input  logic                   i_is_empty,
    output logic                   o_tok_valid,
    input  logic                   i_tok_take,
    output t_tok                   o_tok,
    output logic [VALUE_WIDTH-1:0] o_acc_radix,
    output logic [VALUE_WIDTH-1:0] o_acc_bin,
    output logic [VALUE_WIDTH-1:0] o_acc_hex
);

    logic                   r_in_valid;
    logic [CHAR_WIDTH-1:0]  r_in_char;
    logic                   r_in_last;
    logic                   r_in_empty;

    logic [1:0]             r_pos;
    logic [7:0]             r_held;
    logic [VALUE_WIDTH-1:0] r_acc_radix;
    logic [VALUE_WIDTH-1:0] r_acc_bin;
    logic [VALUE_WIDTH-1:0] r_acc_hex;
    t_flags                 r_flags;

    logic                   go;
    logic                   s1_ready;
    logic [7:0]             upper;
    logic [VALUE_WIDTH-1:0] f_acc_radix;
    logic [VALUE_WIDTH-1:0] f_acc_bin;
    logic [VALUE_WIDTH-1:0] f_acc_hex;
    t_flags                 f_flags;
    logic [VALUE_WIDTH-1:0] x_acc_radix;
    logic [VALUE_WIDTH-1:0] x_acc_bin;
    logic [VALUE_WIDTH-1:0] x_acc_hex;
    t_flags                 x_flags;

    always_comb begin
        if (|r_in_char[CHAR_WIDTH-1:7]) begin
            upper = 8'd0;
        end else if ((r_in_char[7:0] >= CH_LA) && (r_in_char[7:0] <= CH_LZ)) begin
            upper = r_in_char[7:0] - CH_CASE;
        end else begin
            upper = r_in_char[7:0];
        end
    end

    rsti_fold #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_fold (
        .i_acc_radix(r_acc_radix),
        .i_acc_bin  (r_acc_bin),
        .i_acc_hex  (r_acc_hex),
        .i_flags    (r_flags),
        .i_char     (r_held),
        .i_idx      (r_pos - 2'd1),
        .i_radix    (f_fold_radix(i_radix_mode)),
        .o_acc_radix(f_acc_radix),
        .o_acc_bin  (f_acc_bin),
        .o_acc_hex  (f_acc_hex),
        .o_flags    (f_flags)
    );

    always_comb begin
        if (r_pos != 2'd0) begin
            x_acc_radix = f_acc_radix;
            x_acc_bin   = f_acc_bin;
            x_acc_hex   = f_acc_hex;
            x_flags     = f_flags;
        end else begin
            x_acc_radix = r_acc_radix;
            x_acc_bin   = r_acc_bin;
            x_acc_hex   = r_acc_hex;
            x_flags     = r_flags;
        end
    end

    assign go          = r_in_valid && (!r_in_last || i_tok_take);
    assign s1_ready    = !r_in_valid || go;
    assign o_stall     = !s1_ready;
    assign o_tok_valid = r_in_valid && r_in_last;

    assign o_tok.empty = r_in_empty;
    assign o_tok.ch    = upper;
    assign o_tok.pos   = r_pos;
    assign o_tok.flags = x_flags;
    assign o_acc_radix = x_acc_radix;
    assign o_acc_bin   = x_acc_bin;
    assign o_acc_hex   = x_acc_hex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s1_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_in_char  <= i_char_code;
            r_in_last  <= i_last;
            r_in_empty <= i_is_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 2'd0;
            r_held      <= 8'd0;
            r_acc_radix <= '0;
            r_acc_bin   <= '0;
            r_acc_hex   <= '0;
            r_flags     <= '0;
        end else if (go) begin
            if (r_in_last) begin
                r_pos       <= 2'd0;
                r_held      <= 8'd0;
                r_acc_radix <= '0;
                r_acc_bin   <= '0;
                r_acc_hex   <= '0;
                r_flags     <= '0;
            end else begin
                r_pos       <= (r_pos == 2'd3) ? r_pos : r_pos + 2'd1;
                r_held      <= upper;
                r_acc_radix <= x_acc_radix;
                r_acc_bin   <= x_acc_bin;
                r_acc_hex   <= x_acc_hex;
                r_flags     <= x_flags;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/rsti_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rsti_back import rsti_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [MODE_WIDTH-1:0]  i_radix_mode,
    input  logic                   i_tok_valid,
    output logic                   o_tok_take,
    input  t_tok                   i_tok,
    input  logic [VALUE_WIDTH-1:0] i_acc_radix,
    input  logic [VALUE_WIDTH-1:0] i_acc_bin,
    input  logic [VALUE_WIDTH-1:0] i_acc_hex,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic [VALUE_WIDTH-1:0] o_value
);

    logic                   r_s2_valid;
    t_tok                   r_s2_tok;
    logic [VALUE_WIDTH-1:0] r_s2_radix;
    logic [VALUE_WIDTH-1:0] r_s2_bin;
    logic [VALUE_WIDTH-1:0] r_s2_hex;

    logic                   r_out_valid;
    logic [1:0]             r_out_status;
    logic [VALUE_WIDTH-1:0] r_out_value;

    logic                   out_ready;
    logic                   single;
    logic [VALUE_WIDTH-1:0] in_radix;
    logic [VALUE_WIDTH-1:0] in_bin;
    logic [VALUE_WIDTH-1:0] in_hex;
    t_flags                 in_flags;
    logic [1:0]             chk_bin;
    logic [1:0]             chk_dec;
    logic [1:0]             chk_fix;
    logic [1:0]             chk_hex;
    logic [1:0]             chk_hexf;
    logic [1:0]             n_status;
    logic [VALUE_WIDTH-1:0] n_value;

    // {ok, use value before last char}
    function automatic logic [1:0] f_dec(
        input logic [7:0] lc,
        input logic       one,
        input logic [3:0] r,
        input logic       tail,
        input logic [3:0] cls_ex,
        input logic [3:0] cls_in
    );
        logic ok;
        logic ux;
        begin
            ok = 1'b1;
            ux = 1'b0;
            if (lc == CH_D) begin
                ok = (r == RADIX_DEC);
                ux = 1'b1;
            end else if (lc == CH_B) begin
                ok = (r == RADIX_BIN);
                ux = 1'b1;
            end else if (tail && (r != RADIX_DEC)) begin
                ok = 1'b0;
            end
            if (ux && one) begin
                ok = 1'b0;
            end
            if ((ux ? cls_ex : cls_in) >= r) begin
                ok = 1'b0;
            end
            return {ok, ux};
        end
    endfunction

    function automatic logic [1:0] f_hex(
        input logic [7:0] lc,
        input logic       one,
        input logic       tail,
        input t_flags     fl_ex,
        input t_flags     fl_in
    );
        logic ok;
        logic ux;
        begin
            ok = 1'b1;
            ux = (lc == CH_H);
            if (ux && one) begin
                ok = 1'b0;
            end
            if (tail && !fl_in.first_digit) begin
                ok = 1'b0;
            end
            if (tail && !fl_in.prefix && !ux) begin
                ok = 1'b0;
            end
            if (ux ? fl_ex.hex_bad : fl_in.hex_bad) begin
                ok = 1'b0;
            end
            return {ok, ux};
        end
    endfunction

    rsti_fold #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_fold (
        .i_acc_radix(r_s2_radix),
        .i_acc_bin  (r_s2_bin),
        .i_acc_hex  (r_s2_hex),
        .i_flags    (r_s2_tok.flags),
        .i_char     (r_s2_tok.ch),
        .i_idx      (r_s2_tok.pos),
        .i_radix    (f_fold_radix(i_radix_mode)),
        .o_acc_radix(in_radix),
        .o_acc_bin  (in_bin),
        .o_acc_hex  (in_hex),
        .o_flags    (in_flags)
    );

    always_comb begin
        single   = (r_s2_tok.pos == 2'd0);
        chk_bin  = f_dec(r_s2_tok.ch, single, RADIX_BIN, 1'b1,
                         r_s2_tok.flags.max_cls, in_flags.max_cls);
        chk_dec  = f_dec(r_s2_tok.ch, single, RADIX_DEC, 1'b1,
                         r_s2_tok.flags.max_cls, in_flags.max_cls);
        chk_fix  = f_dec(r_s2_tok.ch, single, i_radix_mode[3:0], 1'b0,
                         r_s2_tok.flags.max_cls, in_flags.max_cls);
        chk_hex  = f_hex(r_s2_tok.ch, single, 1'b1, r_s2_tok.flags, in_flags);
        chk_hexf = f_hex(r_s2_tok.ch, single, 1'b0, r_s2_tok.flags, in_flags);
        n_status = ST_OK;
        n_value  = '0;
        if (r_s2_tok.empty) begin
            n_status = ST_MALFORMED;
        end else if (i_radix_mode == MODE_AUTO) begin
            if (chk_bin[1]) begin
                n_value = chk_bin[0] ? r_s2_bin : in_bin;
            end else if (chk_dec[1]) begin
                n_value = chk_dec[0] ? r_s2_radix : in_radix;
            end else if (chk_hex[1]) begin
                n_value = chk_hex[0] ? r_s2_hex : in_hex;
            end else begin
                n_status = ST_NO_RADIX;
            end
        end else if (i_radix_mode inside {[5'd2:5'd10]}) begin
            if (!chk_fix[1]) begin
                n_status = ST_MALFORMED;
            end else if (i_radix_mode[3:0] == RADIX_BIN) begin
                n_value = chk_fix[0] ? r_s2_bin : in_bin;
            end else begin
                n_value = chk_fix[0] ? r_s2_radix : in_radix;
            end
        end else if (i_radix_mode == MODE_HEX) begin
            if (chk_hexf[1]) begin
                n_value = chk_hexf[0] ? r_s2_hex : in_hex;
            end else begin
                n_status = ST_MALFORMED;
            end
        end else begin
            n_status = ST_BAD_RADIX;
        end
    end

    assign out_ready  = !r_out_valid || !i_stall;
    assign o_tok_take = !r_s2_valid || out_ready;
    assign o_valid    = r_out_valid;
    assign o_status   = r_out_status;
    assign o_value    = r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (o_tok_take) begin
            r_s2_valid <= i_tok_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tok_take && i_tok_valid) begin
            r_s2_tok   <= i_tok;
            r_s2_radix <= i_acc_radix;
            r_s2_bin   <= i_acc_bin;
            r_s2_hex   <= i_acc_hex;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s2_valid) begin
            r_out_status <= n_status;
            r_out_value  <= n_value;
        end
    end

endmodule
`default_nettype wire

// ===== verif/radix_string_to_integer_unit_test.sv =====
`timescale 1ns / 1ps
module radix_string_to_integer_unit_test;
    import rsti_pkg::*;

    localparam int LATENCY_CYCLES = 3;
    localparam logic [4:0] MODE_FIXED_LO = 5'd2;
    localparam logic [4:0] MODE_FIXED_HI = 5'd10;
    localparam logic [4:0] MODE_BAD_TOP  = 5'd31;
    localparam logic [4:0] MODE_BAD_LOW  = 5'd1;

    typedef struct packed {
        logic [15:0] code;
        logic        last;
        logic        is_empty;
    } char_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
    } parse_result_t;

    typedef struct packed {
        logic [31:0] acc_radix;
        logic [31:0] acc_bin;
        logic [31:0] acc_hex;
        t_flags      flags;
    } digit_sums_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [15:0]           i_char_code = '0;
    logic                  i_last = 1'b0;
    logic                  i_is_empty = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [1:0]            o_status;
    logic [31:0]           o_value;

    char_beat_t    char_queue[$];
    parse_result_t parse_queue[$];
    logic [15:0]   text_buf[$];
    char_beat_t    cur_beat;
    int            chars_queued = 0;
    int            fail_count = 0;
    int unsigned   cycle_cnt = 0;

    logic [4:0]    mode_reg = MODE_AUTO;
    logic [1:0]    pos_cnt = '0;
    logic [7:0]    held_ch = '0;
    digit_sums_t   sums = '0;

    radix_string_to_integer_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_char_code (i_char_code),
        .i_last      (i_last),
        .i_is_empty  (i_is_empty),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_status    (o_status),
        .o_value     (o_value)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    function automatic logic quiet_cycle();
        if (cycle_cnt % 1500 >= 1100) return 1'b0;
        return $urandom_range(0, 99) < 23;
    endfunction

    function automatic logic [7:0] upcase_code(input logic [15:0] c);
        if (c > 16'd127) return 8'h00;
        if (c[7:0] >= CH_LA && c[7:0] <= CH_LZ) return c[7:0] - CH_CASE;
        return c[7:0];
    endfunction

    function automatic logic [3:0] fold_radix_for(input logic [4:0] mode);
        if (mode >= MODE_FIXED_LO && mode <= MODE_FIXED_HI) return mode[3:0];
        return RADIX_DEC;
    endfunction

    function automatic digit_sums_t fold_char(input digit_sums_t s, input logic [7:0] ch,
                                              input logic [1:0] idx, input logic [3:0] r);
        logic       isdec;
        logic       skip_hex;
        logic [7:0] diff;
        logic [3:0] d;
        logic [3:0] cls;
        logic [3:0] hv;
        t_flags     f;
        isdec = ch >= CH_0 && ch <= CH_9;
        diff = ch - CH_0;
        d = isdec ? diff[3:0] : 4'd0;
        cls = isdec ? d : 4'd15;
        skip_hex = 1'b0;
        f = s.flags;
        if (idx == 2'd0) begin
            if (isdec) f.first_digit = 1'b1;
            if (ch == CH_0) f.first_zero = 1'b1;
        end
        if (idx == 2'd1 && f.first_zero && ch == CH_X) begin
            f.prefix = 1'b1;
            skip_hex = 1'b1;
        end
        if (cls > f.max_cls) f.max_cls = cls;
        if (!skip_hex) begin
            hv = d;
            if (!isdec) begin
                if (ch >= CH_A && ch <= CH_F) begin
                    diff = ch - CH_A + HEX_A_VAL;
                    hv = diff[3:0];
                end else begin
                    f.hex_bad = 1'b1;
                end
            end
            s.acc_hex = s.acc_hex * 16 + hv;
        end
        s.acc_radix = s.acc_radix * r + d;
        s.acc_bin = s.acc_bin * 2 + d;
        s.flags = f;
        return s;
    endfunction

    // {match, value}
    function automatic logic [32:0] dec_match(input digit_sums_t excl, input digit_sums_t incl,
                                              input logic [7:0] lastc, input logic single,
                                              input logic [3:0] r, input logic tail);
        digit_sums_t s;
        logic        suffixed;
        suffixed = 1'b1;
        s = excl;
        if (lastc == CH_D) begin
            if (r != RADIX_DEC) return '0;
        end else if (lastc == CH_B) begin
            if (r != RADIX_BIN) return '0;
        end else begin
            if (tail && r != RADIX_DEC) return '0;
            s = incl;
            suffixed = 1'b0;
        end
        if (suffixed && single) return '0;
        if (s.flags.max_cls >= r) return '0;
        return {1'b1, (r == RADIX_BIN) ? s.acc_bin : s.acc_radix};
    endfunction

    function automatic logic [32:0] hex_match(input digit_sums_t excl, input digit_sums_t incl,
                                              input logic [7:0] lastc, input logic single,
                                              input logic tail);
        digit_sums_t s;
        s = incl;
        if (lastc == CH_H) begin
            if (single) return '0;
            s = excl;
        end
        if (tail) begin
            if (!incl.flags.first_digit) return '0;
            if (!incl.flags.prefix && lastc != CH_H) return '0;
        end
        if (s.flags.hex_bad) return '0;
        return {1'b1, s.acc_hex};
    endfunction

    task automatic clear_string();
        pos_cnt = '0;
        held_ch = '0;
        sums = '0;
    endtask

    task automatic parse_char(input char_beat_t beat);
        logic [7:0]    up;
        logic [3:0]    r;
        logic          single;
        logic [32:0]   chk;
        digit_sums_t   excl;
        digit_sums_t   incl;
        parse_result_t res;
        res = '0;
        if (beat.last && beat.is_empty) begin
            clear_string();
            res.status = ST_MALFORMED;
            parse_queue.push_back(res);
            return;
        end
        up = upcase_code(beat.code);
        r = fold_radix_for(mode_reg);
        if (pos_cnt != 2'd0) sums = fold_char(sums, held_ch, pos_cnt - 2'd1, r);
        if (!beat.last) begin
            held_ch = up;
            if (pos_cnt != 2'd3) pos_cnt = pos_cnt + 2'd1;
            return;
        end
        excl = sums;
        incl = fold_char(sums, up, pos_cnt, r);
        single = pos_cnt == 2'd0;
        if (mode_reg == MODE_AUTO) begin
            res.status = ST_NO_RADIX;
            chk = hex_match(excl, incl, up, single, 1'b1);
            if (chk[32]) res = {ST_OK, chk[31:0]};
            chk = dec_match(excl, incl, up, single, RADIX_DEC, 1'b1);
            if (chk[32]) res = {ST_OK, chk[31:0]};
            chk = dec_match(excl, incl, up, single, RADIX_BIN, 1'b1);
            if (chk[32]) res = {ST_OK, chk[31:0]};
        end else if (mode_reg >= MODE_FIXED_LO && mode_reg <= MODE_FIXED_HI) begin
            chk = dec_match(excl, incl, up, single, mode_reg[3:0], 1'b0);
            res = {chk[32] ? ST_OK : ST_MALFORMED, chk[31:0]};
        end else if (mode_reg == MODE_HEX) begin
            chk = hex_match(excl, incl, up, single, 1'b0);
            res = {chk[32] ? ST_OK : ST_MALFORMED, chk[31:0]};
        end else begin
            res.status = ST_BAD_RADIX;
        end
        if (res.status != ST_OK) res.value = '0;
        clear_string();
        parse_queue.push_back(res);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_char(cur_beat);
            end
            if (!i_valid || !o_stall) begin
                if (char_queue.size() != 0 && !quiet_cycle()) begin
                    cur_beat = char_queue.pop_front();
                    i_valid <= 1'b1;
                    i_char_code <= cur_beat.code;
                    i_last <= cur_beat.last;
                    i_is_empty <= cur_beat.is_empty;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        $display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin
        parse_result_t want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (parse_queue.size() == 0) begin
                    report_mismatch("result with none pending", o_value, 32'h0);
                end else begin
                    want = parse_queue.pop_front();
                    if (o_status !== want.status)
                        report_mismatch("status", {30'h0, o_status}, {30'h0, want.status});
                    if (o_value !== want.value)
                        report_mismatch("value", o_value, want.value);
                end
            end
            i_stall <= quiet_cycle();
        end
    end

    task automatic push_item(input logic [15:0] code, input logic last, input logic is_empty);
        char_queue.push_back({code, last, is_empty});
        chars_queued++;
    endtask

    task automatic commit_text();
        for (int k = 0; k < text_buf.size(); k++) begin
            if (k == text_buf.size() - 1) push_item(text_buf[k], 1'b1, 1'b0);
            else push_item(text_buf[k], 1'b0, 1'($urandom_range(0, 1)));
        end
        text_buf.delete();
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) text_buf.push_back({8'h00, s[k]});
        commit_text();
    endtask

    function automatic logic [15:0] letter_code(input logic [7:0] c);
        if (c >= CH_A && $urandom_range(0, 1)) return {8'h00, c + CH_CASE};
        return {8'h00, c};
    endfunction

    function automatic logic [15:0] digit_code(input int unsigned v);
        logic [7:0] vb;
        vb = 8'(v);
        if (vb < 8'd10) return {8'h00, CH_0 + vb};
        return letter_code(CH_A + vb - HEX_A_VAL);
    endfunction

    function automatic logic [15:0] noise_code();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(0, 4))
            0: return rnd[15:0];
            1: return {9'h000, rnd[6:0]};
            2: begin
                case (rnd[1:0])
                    2'd0: return letter_code(CH_D);
                    2'd1: return letter_code(CH_B);
                    2'd2: return letter_code(CH_H);
                    default: return letter_code(CH_X);
                endcase
            end
            3: return digit_code($urandom_range(0, 15));
            default: begin
                case (rnd[1:0])
                    2'd0: return 16'h0000;
                    2'd1: return 16'hFFFF;
                    2'd2: return 16'h0080;
                    default: return 16'h007F;
                endcase
            end
        endcase
    endfunction

    task automatic build_number(input logic [4:0] mode, input int len);
        int n;
        if (mode == MODE_AUTO) begin
            case ($urandom_range(0, 3))
                0: begin
                    for (int k = 0; k < len; k++) text_buf.push_back(digit_code($urandom_range(0, 1)));
                    text_buf.push_back(letter_code(CH_B));
                end
                1: begin
                    for (int k = 0; k < len; k++) text_buf.push_back(digit_code($urandom_range(0, 9)));
                    if ($urandom_range(0, 1)) text_buf.push_back(letter_code(CH_D));
                end
                2: begin
                    text_buf.push_back({8'h00, CH_0});
                    text_buf.push_back(letter_code(CH_X));
                    for (int k = 0; k < len; k++)
                        text_buf.push_back(digit_code($urandom_range(0, 15)));
                end
                default: begin
                    text_buf.push_back(digit_code($urandom_range(0, 9)));
                    for (int k = 1; k < len; k++)
                        text_buf.push_back(digit_code($urandom_range(0, 15)));
                    text_buf.push_back(letter_code(CH_H));
                end
            endcase
        end else if (mode >= MODE_FIXED_LO && mode <= MODE_FIXED_HI) begin
            for (int k = 0; k < len; k++) text_buf.push_back(digit_code($urandom_range(0, mode - 1)));
            if (mode == RADIX_DEC && $urandom_range(0, 1)) text_buf.push_back(letter_code(CH_D));
            if (mode == RADIX_BIN && $urandom_range(0, 1)) text_buf.push_back(letter_code(CH_B));
        end else if (mode == MODE_HEX) begin
            if ($urandom_range(0, 1)) begin
                text_buf.push_back({8'h00, CH_0});
                text_buf.push_back(letter_code(CH_X));
            end
            n = $urandom_range(0, len);
            for (int k = 0; k < n; k++) text_buf.push_back(digit_code($urandom_range(0, 15)));
            if ($urandom_range(0, 1)) text_buf.push_back(letter_code(CH_H));
            if (text_buf.size() == 0) text_buf.push_back(digit_code($urandom_range(0, 15)));
        end else begin
            for (int k = 0; k < len; k++) text_buf.push_back(digit_code($urandom_range(0, 15)));
        end
    endtask

    task automatic queue_random_string(input logic [4:0] mode);
        int         len;
        int         kind;
        int         n;
        logic [4:0] other;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 34) : $urandom_range(1, 6);
        kind = $urandom_range(0, 99);
        other = 5'($urandom_range(0, 16));
        if (kind < 3) begin
            push_item(noise_code(), 1'b1, 1'b1);
            return;
        end
        if (kind < 78) begin
            build_number(mode, len);
        end else if (kind < 88) begin
            build_number(mode, len);
            text_buf[$urandom_range(0, text_buf.size() - 1)] = noise_code();
        end else if (kind < 93) begin
            build_number(other, len);
        end else begin
            n = $urandom_range(1, 5);
            for (int k = 0; k < n; k++) text_buf.push_back(noise_code());
        end
        commit_text();
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (char_queue.size() != 0 || i_valid || parse_queue.size() != 0);
        repeat (LATENCY_CYCLES + 3) @(posedge i_clk);
    endtask

    task automatic write_radix_mode(input logic [4:0] mode);
        logic [ADDR_WIDTH-1:0] addr;
        addr = ADDR_WIDTH'(4 * IDX_RADIX_MODE);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {27'd0, mode};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mode_reg = mode;
    endtask

    initial begin
        int         start;
        int         target;
        logic [4:0] mode;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_text("101b");
        push_text("0X1f");
        push_item(16'h0041, 1'b1, 1'b1);
        push_text("h");
        push_text("9d");
        push_item(16'h0031, 1'b0, 1'b1);
        push_item(16'hFFFF, 1'b1, 1'b0);
        settle();

        write_radix_mode(MODE_HEX);
        push_text("0x");
        push_text("0xH");
        push_item(16'h0000, 1'b1, 1'b0);
        settle();

        write_radix_mode(MODE_BAD_TOP);
        push_text("7");
        settle();

        // switch radix with a string half received
        write_radix_mode(5'(RADIX_BIN));
        push_item({8'h00, CH_0 + 8'd1}, 1'b0, 1'b0);
        push_item({8'h00, CH_0 + 8'd1}, 1'b0, 1'b0);
        settle();
        write_radix_mode(5'(RADIX_DEC));
        push_item({8'h00, CH_9}, 1'b1, 1'b0);
        settle();

        for (int p = 0; p < 10; p++) begin
            case (p)
                0, 9: mode = MODE_AUTO;
                1: mode = MODE_HEX;
                2: mode = 5'(RADIX_BIN);
                3: mode = 5'(RADIX_DEC);
                5: mode = MODE_BAD_TOP;
                7: mode = MODE_BAD_LOW;
                8: begin
                    mode = 5'($urandom_range(11, 30));
                    if (mode == MODE_HEX) mode = mode + 5'd1;
                end
                default: mode = 5'($urandom_range(3, 9));
            endcase
            target = (p == 5 || p == 7 || p == 8) ? 30 : 165;
            write_radix_mode(mode);
            start = chars_queued;
            while (chars_queued - start < target) queue_random_string(mode);
            settle();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
